// ===== hdl/itoa_pkg.sv =====
// Shared types and constants for the integer-to-ASCII radix converter.
// Used by itoa_div, itoa_digit_stack and integer_to_ascii_radix_top; no dependencies.
package itoa_pkg;

    localparam int VALUE_BITS = 32;
    localparam int RADIX_W    = 6;
    localparam int CHAR_W     = 7;
    localparam int STEP_W     = $clog2(VALUE_BITS);
    localparam int PTR_W      = $clog2(VALUE_BITS);
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] DECIMAL   = RADIX_W'(10);

    localparam logic [CHAR_W-1:0] CH_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CH_A     = CHAR_W'(97);
    localparam logic [CHAR_W-1:0] CH_MINUS = CHAR_W'(45);
    localparam logic [CHAR_W-1:0] CH_NONE  = CHAR_W'(0);

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic [RADIX_W-1:0]           radix;
    } in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
        logic              bad_radix;
    } out_t;

    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [RADIX_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] quotient;
        logic [RADIX_W-1:0]    remainder;
    } div_rsp_t;

    typedef struct packed {
        logic              push;
        logic [CHAR_W-1:0] push_char;
        logic              pop;
    } stk_ctl_t;

    typedef struct packed {
        logic [CHAR_W-1:0] top_char;
        logic [CNT_W-1:0]  count;
    } stk_stat_t;

    // Digit value 0..35 to '0'..'9', 'a'..'z'
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] dw;
        dw = CHAR_W'(d);
        if (d < RADIX_W'(10)) begin
            digit_char = CH_ZERO + dw;
        end else begin
            digit_char = CH_A - CHAR_W'(10) + dw;
        end
    endfunction

endpackage

// ===== hdl/integer_to_ascii_radix_top.sv =====
// Integer-to-ASCII radix converter: sequencer, divider and digit stack.
// Depends on itoa_pkg, itoa_div and itoa_digit_stack.
//
//   channel   direction  ports                         payload
//   s_        in         s_valid, s_ready, s_payload   value (signed 32), radix (6)
//   m_        out        m_valid, m_ready, m_payload   character (7), last, bad_radix
//
// Each digit costs one pass of the shared divider. s_ready is high only between requests.
// Reset is synchronous, active low, and clears the sequencer, divider and stack count.
// A stalled m_ready holds the current character and pauses emission.
module integer_to_ascii_radix_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  itoa_pkg::in_t  s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output itoa_pkg::out_t m_payload
);
    import itoa_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_SIGN = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;
    localparam logic [2:0] ST_ERR  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic               neg_reg, neg_next;
    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_payload_reg, m_payload_next;

    logic                  accept;
    logic                  radix_ok;
    logic                  in_neg;
    logic [VALUE_BITS-1:0] in_mag;
    logic                  out_free;

    div_req_t  div_req;
    div_rsp_t  div_rsp;
    stk_ctl_t  stk_ctl;
    stk_stat_t stk_stat;

    itoa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    itoa_digit_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (stk_ctl),
        .stat    (stk_stat)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign radix_ok = s_payload.radix inside {[RADIX_MIN:RADIX_MAX]};
    assign in_neg   = (s_payload.radix == DECIMAL) && s_payload.value[VALUE_BITS-1];
    assign in_mag   = in_neg ? (VALUE_BITS'(0) - VALUE_BITS'(s_payload.value))
                             : VALUE_BITS'(s_payload.value);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        radix_next     = radix_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;

        div_req.start    = 1'b0;
        div_req.dividend = div_rsp.quotient;
        div_req.divisor  = radix_reg;

        stk_ctl.push      = 1'b0;
        stk_ctl.push_char = digit_char(div_rsp.remainder);
        stk_ctl.pop       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    neg_next   = in_neg;
                    radix_next = s_payload.radix;
                    if (radix_ok) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = in_mag;
                        div_req.divisor  = s_payload.radix;
                        state_next       = ST_DIV;
                    end else begin
                        state_next = ST_ERR;
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    stk_ctl.push = 1'b1;
                    // restart on the quotient until it runs out
                    if (div_rsp.quotient != '0) begin
                        div_req.start = 1'b1;
                    end else begin
                        state_next = neg_reg ? ST_SIGN : ST_EMIT;
                    end
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_payload_next = '{character: CH_MINUS, last: 1'b0, bad_radix: 1'b0};
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    stk_ctl.pop    = 1'b1;
                    m_valid_next   = 1'b1;
                    m_payload_next = '{character: stk_stat.top_char,
                                       last: (stk_stat.count == CNT_W'(1)),
                                       bad_radix: 1'b0};
                    if (stk_stat.count == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_payload_next = '{character: CH_NONE, last: 1'b1, bad_radix: 1'b1};
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg       <= neg_next;
        radix_reg     <= radix_next;
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

// ===== hdl/itoa_div.sv =====
// Shared restoring divider: one quotient bit per cycle.
// Depends on itoa_pkg.
module itoa_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  itoa_pkg::div_req_t req,
    output itoa_pkg::div_rsp_t rsp
);
    import itoa_pkg::*;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(VALUE_BITS - 1);

    logic [VALUE_BITS-1:0] q_reg;
    logic [RADIX_W-1:0]    r_reg;
    logic [RADIX_W-1:0]    d_reg;
    logic [STEP_W-1:0]     cnt_reg;
    logic                  busy_reg;

    logic [RADIX_W:0]      trial;
    logic                  fits;
    logic [RADIX_W:0]      r_step;
    logic [VALUE_BITS-1:0] q_step;

    always_comb begin
        trial  = {r_reg, q_reg[VALUE_BITS-1]};
        fits   = trial >= {1'b0, d_reg};
        r_step = fits ? (trial - {1'b0, d_reg}) : trial;
        q_step = {q_reg[VALUE_BITS-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            q_reg    <= req.dividend;
            d_reg    <= req.divisor;
            r_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            q_reg   <= q_step;
            r_reg   <= r_step[RADIX_W-1:0];
            cnt_reg <= cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Results are valid in the cycle of the final step
    assign rsp.done      = busy_reg && (cnt_reg == STEP_LAST);
    assign rsp.quotient  = q_step;
    assign rsp.remainder = r_step[RADIX_W-1:0];

endmodule

// ===== hdl/itoa_digit_stack.sv =====
// Last-in first-out store of digit characters, so digits leave most significant first.
// Depends on itoa_pkg.
module itoa_digit_stack (
    input  logic                aclk,
    input  logic                aresetn,
    input  itoa_pkg::stk_ctl_t  ctl,
    output itoa_pkg::stk_stat_t stat
);
    import itoa_pkg::*;

    logic [CHAR_W-1:0] mem [VALUE_BITS];
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  top_idx;

    assign top_idx = cnt_reg - CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (ctl.push) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end else if (ctl.pop) begin
            cnt_reg <= top_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            mem[cnt_reg[PTR_W-1:0]] <= ctl.push_char;
        end
    end

    assign stat.top_char = mem[top_idx[PTR_W-1:0]];
    assign stat.count    = cnt_reg;

endmodule
